[rtl/swept_circle_nearest_hit_core_defines.svh]
// Assertion macros used by the top file of the swept circle cast core.
`ifndef SWEPT_CIRCLE_NEAREST_HIT_CORE_DEFINES_SVH
`define SWEPT_CIRCLE_NEAREST_HIT_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SCNH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scnh: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SCNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scnh: next-cycle check failed");

`endif

[rtl/scnh_pkg.sv]
package scnh_pkg;

   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 144;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ONE_SHIFT   = 14;
   localparam int DIV_STEPS   = 15;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAST_RADIUS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Y        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_SX, ST_MUL_SY, ST_MUL_QX, ST_MUL_QY, ST_Q_FIN, ST_ABSQ,
      ST_MUL_H, ST_SQRT_H_GO, ST_SQRT_H, ST_PICK, ST_CMP, ST_MUL_PY, ST_PT_Y,
      ST_VEC, ST_MAG, ST_NORM, ST_MUL_UY, ST_SUM_SQ, ST_SQRT_L, ST_DIV_X,
      ST_DIVY_GO, ST_DIV_Y, ST_COMMIT, ST_FINISH
   } scnh_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_SX, OP_MUL_SY, OP_MUL_QX, OP_MUL_QY, OP_Q_FIN,
      OP_ABSQ, OP_MUL_H, OP_SQRT_H, OP_ROOTS, OP_PICK, OP_MUL_PX, OP_MUL_PY,
      OP_PT_Y, OP_VEC, OP_MAG, OP_NORM, OP_MUL_UX, OP_MUL_UY, OP_SQRT_L,
      OP_DIVX_INIT, OP_DIV_STEP, OP_DIVY_INIT, OP_COMMIT, OP_EMIT
   } scnh_op_type;

   typedef struct packed {
      scnh_op_type op;
   } scnh_cmd_type;

   typedef struct packed {
      logic is_circle;
      logic last;
      logic miss;
      logic better;
      logic sqrt_busy;
      logic norm_done;
      logic mag_zero;
      logic rsp_busy;
   } scnh_status_type;

endpackage

[rtl/scnh_sqrt.sv]
module scnh_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);
   logic [63:0] rad_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [34:0] rem_sh;
   logic [34:0] trial;

   // Two radicand bits enter the partial remainder per step.
   assign rem_sh = {rem_ff[32:0], rad_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

[rtl/scnh_ctrl.sv]
module scnh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  scnh_pkg::scnh_status_type status,
   output scnh_pkg::scnh_cmd_type    cmd
);
   import scnh_pkg::*;

   scnh_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 cnt_last;

   assign cnt_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL_SX;
            end
         end
         ST_MUL_SX: begin
            if (!status.is_circle) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_MUL_SX;
               state_in = ST_MUL_SY;
            end
         end
         ST_MUL_SY: begin
            cmd.op   = OP_MUL_SY;
            state_in = ST_MUL_QX;
         end
         ST_MUL_QX: begin
            cmd.op   = OP_MUL_QX;
            state_in = ST_MUL_QY;
         end
         ST_MUL_QY: begin
            cmd.op   = OP_MUL_QY;
            state_in = ST_Q_FIN;
         end
         ST_Q_FIN: begin
            cmd.op   = OP_Q_FIN;
            state_in = ST_ABSQ;
         end
         ST_ABSQ: begin
            cmd.op   = OP_ABSQ;
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            if (status.miss) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_MUL_H;
               state_in = ST_SQRT_H_GO;
            end
         end
         ST_SQRT_H_GO: begin
            cmd.op   = OP_SQRT_H;
            state_in = ST_SQRT_H;
         end
         ST_SQRT_H: begin
            if (!status.sqrt_busy) begin
               cmd.op   = OP_ROOTS;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.op   = OP_PICK;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.better) begin
               cmd.op   = OP_MUL_PX;
               state_in = ST_MUL_PY;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL_PY: begin
            cmd.op   = OP_MUL_PY;
            state_in = ST_PT_Y;
         end
         ST_PT_Y: begin
            cmd.op   = OP_PT_Y;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            cmd.op   = OP_VEC;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.op   = OP_MAG;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.mag_zero) begin
               state_in = ST_COMMIT;
            end else if (status.norm_done) begin
               cmd.op   = OP_MUL_UX;
               state_in = ST_MUL_UY;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         ST_MUL_UY: begin
            cmd.op   = OP_MUL_UY;
            state_in = ST_SUM_SQ;
         end
         ST_SUM_SQ: begin
            cmd.op   = OP_SQRT_L;
            state_in = ST_SQRT_L;
         end
         ST_SQRT_L: begin
            if (!status.sqrt_busy) begin
               cmd.op   = OP_DIVX_INIT;
               cnt_in   = '0;
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_DIVY_GO;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIVY_GO: begin
            cmd.op   = OP_DIVY_INIT;
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

[rtl/scnh_dpath.sv]
module scnh_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  scnh_pkg::scnh_cmd_type              cmd,
   output scnh_pkg::scnh_status_type           status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scnh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scnh_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [scnh_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [scnh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);
   import scnh_pkg::*;

   function automatic logic signed [67:0] rnd14(input logic signed [67:0] x);
      rnd14 = (x + (68'sd1 <<< (ONE_SHIFT - 1))) >>> ONE_SHIFT;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // Configuration registers.
   logic signed [31:0] orig_x_ff, orig_y_ff;
   logic [30:0]        cast_r_ff, max_d_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff;

   // Item registers.
   logic signed [32:0] cx_ff, cy_ff;
   logic signed [33:0] ocx_ff, ocy_ff;
   logic [31:0]        rsum_ff;
   logic               circ_ff, last_ff;
   logic [15:0]        id_ff;

   // Working registers.
   logic signed [67:0] prod_ff, acc_ff;
   logic signed [37:0] s_ff, q_ff;
   logic               miss_ff;
   logic [31:0]        hd_ff;
   logic [32:0]        hs_ff;
   logic signed [38:0] tn_ff, tf_ff;
   logic               ok_ff;
   logic [30:0]        t_ff;
   logic signed [35:0] px_ff, py_ff;
   logic signed [36:0] vx_ff, vy_ff;
   logic [36:0]        ux_ff, uy_ff;
   logic               sx_ff, sy_ff, zero_ff;
   logic [45:0]        num_ff, dvs_ff;
   logic [14:0]        quo_ff, rx_ff;

   // Running best hit of the open cast.
   logic               cast_open_ff, best_valid_ff;
   logic [30:0]        best_dist_ff;
   logic [15:0]        best_body_ff;
   logic [31:0]        best_px_ff, best_py_ff;
   logic [15:0]        best_nx_ff, best_ny_ff;

   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_user_ff;

   // Combinational helpers.
   logic signed [31:0] bpx_w, bpy_w, offx_w, offy_w;
   logic signed [32:0] cx_w, cy_w;
   logic signed [33:0] mul_a, mul_b;
   logic               mul_en;
   logic signed [67:0] sum_rnd, dif_rnd, prod_rnd;
   logic signed [37:0] aq_w;
   logic signed [38:0] neg_s;
   logic signed [38:0] maxd_w;
   logic               okn_w, okf_w;
   logic [36:0]        uor_w;
   logic               sqrt_start, sqrt_busy;
   logic [63:0]        sqrt_in;
   logic [31:0]        root_w;
   logic [15:0]        nx_w, ny_w;

   assign bpx_w  = $signed(req_tdata[31:0]);
   assign bpy_w  = $signed(req_tdata[63:32]);
   assign offx_w = $signed(req_tdata[95:64]);
   assign offy_w = $signed(req_tdata[127:96]);
   assign cx_w   = {bpx_w[31], bpx_w} + {offx_w[31], offx_w};
   assign cy_w   = {bpy_w[31], bpy_w} + {offy_w[31], offy_w};

   assign sum_rnd  = rnd14(acc_ff + prod_ff);
   assign dif_rnd  = rnd14(acc_ff - prod_ff);
   assign prod_rnd = rnd14(prod_ff);
   assign aq_w     = q_ff[37] ? -q_ff : q_ff;
   assign neg_s    = -{s_ff[37], s_ff};
   assign maxd_w   = {8'b0, max_d_ff};
   assign okn_w    = !tn_ff[38] && (tn_ff <= maxd_w);
   assign okf_w    = !tf_ff[38] && (tf_ff <= maxd_w);
   assign uor_w    = ux_ff | uy_ff;
   assign nx_w     = zero_ff ? 16'd0 : (sx_ff ? -{1'b0, rx_ff} : {1'b0, rx_ff});
   assign ny_w     = zero_ff ? 16'd0 : (sy_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff});

   // One shared signed multiplier; its product is registered.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_MUL_SX: begin
            mul_a = ocx_ff;
            mul_b = {{18{dir_x_ff[15]}}, dir_x_ff};
         end
         OP_MUL_SY: begin
            mul_a = ocy_ff;
            mul_b = {{18{dir_y_ff[15]}}, dir_y_ff};
         end
         OP_MUL_QX: begin
            mul_a = ocx_ff;
            mul_b = {{18{dir_y_ff[15]}}, dir_y_ff};
         end
         OP_MUL_QY: begin
            mul_a = ocy_ff;
            mul_b = {{18{dir_x_ff[15]}}, dir_x_ff};
         end
         OP_MUL_H: begin
            mul_a = {2'b0, hd_ff};
            mul_b = {1'b0, hs_ff};
         end
         OP_MUL_PX: begin
            mul_a = {{18{dir_x_ff[15]}}, dir_x_ff};
            mul_b = {3'b0, t_ff};
         end
         OP_MUL_PY: begin
            mul_a = {{18{dir_y_ff[15]}}, dir_y_ff};
            mul_b = {3'b0, t_ff};
         end
         OP_MUL_UX: begin
            mul_a = {4'b0, ux_ff[29:0]};
            mul_b = {4'b0, ux_ff[29:0]};
         end
         OP_MUL_UY: begin
            mul_a = {4'b0, uy_ff[29:0]};
            mul_b = {4'b0, uy_ff[29:0]};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign sqrt_start = (cmd.op == OP_SQRT_H) || (cmd.op == OP_SQRT_L);
   assign sqrt_in    = (cmd.op == OP_SQRT_H) ? prod_ff[63:0]
                                             : acc_ff[63:0] + prod_ff[63:0];

   scnh_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_in),
      .busy     (sqrt_busy),
      .root     (root_w)
   );

   // Configuration writes; reserved indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         orig_x_ff <= '0;
         orig_y_ff <= '0;
         cast_r_ff <= '0;
         dir_x_ff  <= 16'sd16384;
         dir_y_ff  <= '0;
         max_d_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:     orig_x_ff <= $signed(csr_data);
            CSR_ORIGIN_Y:     orig_y_ff <= $signed(csr_data);
            CSR_CAST_RADIUS:  cast_r_ff <= csr_data[30:0];
            CSR_DIR_X:        dir_x_ff  <= $signed(csr_data[15:0]);
            CSR_DIR_Y:        dir_y_ff  <= $signed(csr_data[15:0]);
            CSR_MAX_DISTANCE: max_d_ff  <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   // Control state of the cast and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cast_open_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.op == OP_LOAD) begin
            cast_open_ff <= 1'b1;
            if (!cast_open_ff) begin
               best_valid_ff <= 1'b0;
            end
         end else if (cmd.op == OP_COMMIT) begin
            best_valid_ff <= 1'b1;
         end else if (cmd.op == OP_EMIT) begin
            cast_open_ff <= 1'b0;
         end
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cx_ff   <= cx_w;
            cy_ff   <= cy_w;
            ocx_ff  <= {{2{orig_x_ff[31]}}, orig_x_ff} - {cx_w[32], cx_w};
            ocy_ff  <= {{2{orig_y_ff[31]}}, orig_y_ff} - {cy_w[32], cy_w};
            rsum_ff <= {1'b0, cast_r_ff} + {1'b0, req_tdata[158:128]};
            circ_ff <= req_tuser;
            last_ff <= req_tlast;
            id_ff   <= req_tdata[174:159];
            if (!cast_open_ff) begin
               best_dist_ff <= max_d_ff;
            end
         end
         OP_MUL_SY, OP_MUL_QY, OP_MUL_UY: begin
            acc_ff <= prod_ff;
         end
         OP_MUL_QX: begin
            s_ff <= sum_rnd[37:0];
         end
         OP_Q_FIN: begin
            q_ff <= dif_rnd[37:0];
         end
         OP_ABSQ: begin
            miss_ff <= (aq_w > $signed({6'b0, rsum_ff}));
            hd_ff   <= rsum_ff - aq_w[31:0];
            hs_ff   <= {1'b0, rsum_ff} + {1'b0, aq_w[31:0]};
         end
         OP_ROOTS: begin
            tn_ff <= neg_s - $signed({7'b0, root_w});
            tf_ff <= neg_s + $signed({7'b0, root_w});
         end
         OP_PICK: begin
            ok_ff <= okn_w || okf_w;
            t_ff  <= okn_w ? tn_ff[30:0] : tf_ff[30:0];
         end
         OP_MUL_PY: begin
            px_ff <= {{4{orig_x_ff[31]}}, orig_x_ff} + prod_rnd[35:0];
         end
         OP_PT_Y: begin
            py_ff <= {{4{orig_y_ff[31]}}, orig_y_ff} + prod_rnd[35:0];
         end
         OP_VEC: begin
            vx_ff <= {px_ff[35], px_ff} - {{4{cx_ff[32]}}, cx_ff};
            vy_ff <= {py_ff[35], py_ff} - {{4{cy_ff[32]}}, cy_ff};
         end
         OP_MAG: begin
            ux_ff   <= vx_ff[36] ? 37'(-vx_ff) : 37'(vx_ff);
            uy_ff   <= vy_ff[36] ? 37'(-vy_ff) : 37'(vy_ff);
            sx_ff   <= vx_ff[36];
            sy_ff   <= vy_ff[36];
            zero_ff <= (vx_ff == '0) && (vy_ff == '0);
         end
         OP_NORM: begin
            // Bring the larger magnitude into [2^29, 2^30), one bit a cycle.
            if (uor_w[36:30] != '0) begin
               ux_ff <= ux_ff >> 1;
               uy_ff <= uy_ff >> 1;
            end else begin
               ux_ff <= ux_ff << 1;
               uy_ff <= uy_ff << 1;
            end
         end
         OP_DIVX_INIT: begin
            num_ff <= {2'b0, ux_ff[29:0], 14'b0};
            dvs_ff <= {root_w, 14'b0};
            quo_ff <= '0;
         end
         OP_DIVY_INIT: begin
            rx_ff  <= quo_ff;
            num_ff <= {2'b0, uy_ff[29:0], 14'b0};
            dvs_ff <= {root_w, 14'b0};
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            dvs_ff <= dvs_ff >> 1;
            if (num_ff >= dvs_ff) begin
               num_ff <= num_ff - dvs_ff;
               quo_ff <= {quo_ff[13:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[13:0], 1'b0};
            end
         end
         OP_COMMIT: begin
            best_dist_ff <= t_ff;
            best_body_ff <= id_ff;
            best_px_ff   <= sat32(px_ff);
            best_py_ff   <= sat32(py_ff);
            best_nx_ff   <= nx_w;
            best_ny_ff   <= ny_w;
         end
         OP_EMIT: begin
            rsp_user_ff <= best_valid_ff;
            if (best_valid_ff) begin
               rsp_data_ff <= {1'b0, best_ny_ff, best_nx_ff, best_py_ff, best_px_ff,
                               best_dist_ff, best_body_ff};
            end else begin
               rsp_data_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign status.is_circle = circ_ff;
   assign status.last      = last_ff;
   assign status.miss      = miss_ff;
   assign status.better    = ok_ff && (t_ff < best_dist_ff);
   assign status.sqrt_busy = sqrt_busy;
   assign status.norm_done = (uor_w[36:30] == '0) && uor_w[29];
   assign status.mag_zero  = zero_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

[rtl/swept_circle_nearest_hit_core.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready   tdata candidate, tuser circle flag, tlast end
// rsp_      out        rsp_tvalid/rsp_tready   tdata nearest hit, tuser hit flag
// csr_      in         csr_valid/csr_ready     csr_index register, csr_data value
//
// One item is worked on at a time. A skipped item does no arithmetic, a missed
// circle stops after the miss test, a circle that does not beat the current best
// runs one 32-step square root, and a new nearest hit also runs a normalizing
// shifter, a second square root and two 15-step divides.
// Reset is synchronous and active high; it restores the register defaults and
// closes any open cast. An item with tlast waits on a stalled result before its
// own result is loaded; csr writes are always taken.
`include "swept_circle_nearest_hit_core_defines.svh"

module swept_circle_nearest_hit_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, from bit 0: body_pos_x[31:0], body_pos_y[31:0], offset_x[31:0],
   // offset_y[31:0], circle_radius[30:0], body_id[15:0], one zero pad bit.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [scnh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: is_circle.
   input  logic                               req_tuser,
   // req_tlast: last_item.
   input  logic                               req_tlast,
   // rsp_tdata, from bit 0: hit_id[15:0], hit_distance[30:0], hit_point_x[31:0],
   // hit_point_y[31:0], normal_x[15:0], normal_y[15:0], one zero pad bit.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [scnh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: hit.
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scnh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scnh_pkg::CSR_DATA_W-1:0]    csr_data
);
   import scnh_pkg::*;

   scnh_cmd_type    cmd;
   scnh_status_type status;
   logic            rsp_nx_in_range, rsp_ny_in_range;

   // The controller steps each item through the shared multiplier, square root
   // and divider held in the datapath.
   scnh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scnh_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign rsp_nx_in_range = ($signed(rsp_tdata[126:111]) <= 16'sd16384) &&
                            ($signed(rsp_tdata[126:111]) >= -16'sd16384);
   assign rsp_ny_in_range = ($signed(rsp_tdata[142:127]) <= 16'sd16384) &&
                            ($signed(rsp_tdata[142:127]) >= -16'sd16384);

   // A result without a hit carries all zero fields.
   `SCNH_ASSERT_IMPL(a_nohit_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   // Only one item is in work: an accepted item closes the input.
   `SCNH_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // A reported normal stays within unit length per component.
   `SCNH_ASSERT_IMPL(a_normal_x, clock, reset, rsp_tvalid && rsp_tuser, rsp_nx_in_range)
   `SCNH_ASSERT_IMPL(a_normal_y, clock, reset, rsp_tvalid && rsp_tuser, rsp_ny_in_range)
endmodule

[test/swept_circle_nearest_hit_checker.sv]
module swept_circle_nearest_hit_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [scnh_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [scnh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [scnh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scnh_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending,
   output int                               result_count,
   output int                               hit_count
);
   import scnh_pkg::*;

   typedef struct {
      logic               hit;
      logic [15:0]        id;
      logic [30:0]        hit_dist;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
   } cast_result_type;

   cast_result_type expected_casts[$];

   // Register copies.
   logic signed [31:0] org_x, org_y;
   logic [30:0]        sweep_rad, max_dist;
   logic signed [15:0] dir_x, dir_y;

   // Running nearest hit of the open cast.
   longint             near_dist;
   logic               near_valid;
   logic [15:0]        near_id;
   logic signed [31:0] near_px, near_py;
   logic signed [15:0] near_nx, near_ny;
   logic               cast_open;

   function automatic longint round_q14(longint x);
      return (x + 8192) >>> 14;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Unit vector in Q2.14: normalize the larger magnitude into [2^29, 2^30),
   // then divide each magnitude by the integer length.
   function automatic void unit_vec(input longint vx, input longint vy,
                                    output logic signed [15:0] nx,
                                    output logic signed [15:0] ny);
      longint unsigned ux, uy, mx, len, rx, ry;
      ux = vx < 0 ? -vx : vx;
      uy = vy < 0 ? -vy : vy;
      mx = ux > uy ? ux : uy;
      if (mx == 0) begin
         nx = 0;
         ny = 0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         ux >>= 1; uy >>= 1; mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         ux <<= 1; uy <<= 1; mx <<= 1;
      end
      len = int_sqrt(ux * ux + uy * uy);
      rx = ux * 16384 / len;
      ry = uy * 16384 / len;
      nx = vx < 0 ? -rx[15:0] : rx[15:0];
      ny = vy < 0 ? -ry[15:0] : ry[15:0];
   endfunction

   function automatic void take_candidate(logic [REQ_DATA_W-1:0] d, logic circ);
      longint ox, oy, dx, dy, cx, cy, ocx, ocy, s, q, aq, r, ch, t, px, py, md;
      logic ok;
      md = longint'(max_dist);
      if (!circ) return;
      ox = org_x;
      oy = org_y;
      dx = dir_x;
      dy = dir_y;
      cx = longint'($signed(d[31:0])) + longint'($signed(d[95:64]));
      cy = longint'($signed(d[63:32])) + longint'($signed(d[127:96]));
      ocx = ox - cx;
      ocy = oy - cy;
      s = round_q14(ocx * dx + ocy * dy);
      q = round_q14(ocx * dy - ocy * dx);
      r = longint'(sweep_rad) + longint'(d[158:128]);
      aq = q < 0 ? -q : q;
      if (aq > r) return;
      ch = int_sqrt(longint'(r - aq) * longint'(r + aq));
      t = -s - ch;
      ok = 1'b1;
      if (t < 0 || t > md) begin
         t = -s + ch;
         if (t < 0 || t > md) ok = 1'b0;
      end
      if (ok && t < near_dist) begin
         px = ox + round_q14(dx * t);
         py = oy + round_q14(dy * t);
         near_dist = t;
         near_valid = 1'b1;
         near_id = d[174:159];
         near_px = clamp32(px);
         near_py = clamp32(py);
         unit_vec(px - cx, py - cy, near_nx, near_ny);
      end
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cast_result_type e;
      if (reset) begin
         org_x = 0; org_y = 0; sweep_rad = 0; max_dist = 0;
         dir_x = 16'sd16384; dir_y = 0;
         cast_open = 1'b0; near_valid = 1'b0;
         expected_casts.delete();
         fail_count = 0; result_count = 0; hit_count = 0;
      end else begin
         // Results are checked before this edge's item is predicted; a result
         // can never belong to an item accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_casts.size() == 0) begin
               $display("%0t: result arrived with nothing expected, actual tdata %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               e = expected_casts.pop_front();
               check_field("hit", e.hit, rsp_tuser);
               check_field("hit_id", e.id, rsp_tdata[15:0]);
               check_field("hit_distance", e.hit_dist, rsp_tdata[46:16]);
               check_field("hit_point_x", e.px, $signed(rsp_tdata[78:47]));
               check_field("hit_point_y", e.py, $signed(rsp_tdata[110:79]));
               check_field("normal_x", e.nx, $signed(rsp_tdata[126:111]));
               check_field("normal_y", e.ny, $signed(rsp_tdata[142:127]));
               result_count++;
               if (e.hit) hit_count++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:     org_x = csr_data;
               CSR_ORIGIN_Y:     org_y = csr_data;
               CSR_CAST_RADIUS:  sweep_rad = csr_data[30:0];
               CSR_DIR_X:        dir_x = csr_data[15:0];
               CSR_DIR_Y:        dir_y = csr_data[15:0];
               CSR_MAX_DISTANCE: max_dist = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (!cast_open) begin
               near_dist = longint'(max_dist);
               near_valid = 1'b0;
               near_id = 0; near_px = 0; near_py = 0; near_nx = 0; near_ny = 0;
               cast_open = 1'b1;
            end
            take_candidate(req_tdata, req_tuser);
            if (req_tlast) begin
               cast_open = 1'b0;
               e.hit = near_valid;
               e.id = near_valid ? near_id : '0;
               e.hit_dist = near_valid ? near_dist[30:0] : '0;
               e.px = near_valid ? near_px : '0;
               e.py = near_valid ? near_py : '0;
               e.nx = near_valid ? near_nx : '0;
               e.ny = near_valid ? near_ny : '0;
               expected_casts = {expected_casts, e};
            end
         end
      end
      pending = expected_casts.size();
   end

endmodule

[test/tb_swept_circle_nearest_hit_core.sv]
// Testbench for the swept circle cast core. The checker beside the block
// predicts every cast result; this module only makes stimulus and judges.
module tb_swept_circle_nearest_hit_core;
   import scnh_pkg::*;

   localparam longint ONE = 65536;
   // Index past the register list; a write there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int TOTAL_ITEMS = 1750;
   // Longest item the block can take, plus margin, used for idle waits.
   localparam int SETTLE_CYCLES = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int fail_count, pending, result_count, hit_count;

   // Burst state of the sender and the running item count.
   int burst_left = 0;
   int items_sent = 0;
   int stall_tick = 0;

   // The setting the geometric candidates are aimed with.
   longint cfg_ox, cfg_oy, cfg_dx, cfg_dy, cfg_rad, cfg_maxd;

   always #5 clock = ~clock;

   swept_circle_nearest_hit_core u_dut (.*);

   swept_circle_nearest_hit_checker u_checker (.*);

   // The receiver cycles through four stall patterns: always ready, coin
   // flips, long stalls with short ready windows, and a fast toggle.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (stall_tick[4:0] < 4);
         default: rsp_tready <= ~stall_tick[2];
      endcase
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[31:0];
      @(posedge clock iff (csr_valid && csr_ready));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(longint ox, longint oy, longint rad,
                             longint dx, longint dy, longint maxd);
      cfg_ox = ox; cfg_oy = oy; cfg_rad = rad;
      cfg_dx = dx; cfg_dy = dy; cfg_maxd = maxd;
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_CAST_RADIUS, rad);
      write_reg(CSR_DIR_X, dx);
      write_reg(CSR_DIR_Y, dy);
      write_reg(CSR_MAX_DISTANCE, maxd);
   endtask

   // Drives one candidate and holds it until the block takes it. Between
   // bursts the valid may drop for a random gap; inside a burst it stays high.
   task automatic send_item(longint bx, longint by, longint ofx, longint ofy,
                            longint rad, logic circ, longint id, logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, id[15:0], rad[30:0], ofy[31:0], ofx[31:0], by[31:0], bx[31:0]};
      req_tuser  <= circ;
      req_tlast  <= last;
      @(posedge clock iff (req_tvalid && req_tready));
      items_sent++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   // Waits until every cast result has come back, then lets the block settle.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A candidate placed near the swept path: a random distance along the
   // direction and a random side offset around the combined radius.
   task automatic send_aimed(logic last);
      longint span, t, perp, rr, rad, cx, cy, ofx, ofy;
      span = cfg_maxd > 400 * ONE ? 400 * ONE : cfg_maxd + 4 * ONE;
      t = longint'($urandom_range(0, span[31:0] + span[31:0] / 4)) - span / 4;
      rad = $urandom_range(0, 8 * ONE);
      rr = (cfg_rad > 64 * ONE ? 64 * ONE : cfg_rad) + rad + ONE;
      perp = longint'($urandom_range(0, 2 * rr)) - rr;
      cx = cfg_ox + ((cfg_dx * t) >>> 14) - ((cfg_dy * perp) >>> 14);
      cy = cfg_oy + ((cfg_dy * t) >>> 14) + ((cfg_dx * perp) >>> 14);
      ofx = longint'($urandom_range(0, 32 * ONE)) - 16 * ONE;
      ofy = longint'($urandom_range(0, 32 * ONE)) - 16 * ONE;
      send_item(cx - ofx, cy - ofy, ofx, ofy, rad, $urandom_range(0, 9) != 0,
                $urandom_range(0, 65535), last);
   endtask

   task automatic send_noise(logic last);
      send_item($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1), $urandom_range(0, 65535), last);
   endtask

   task automatic random_config();
      longint ox, oy, rad, dx, dy, maxd;
      real a;
      if ($urandom_range(0, 4) == 0) begin
         ox = $urandom_range(0, 1) ? 32'sh7FFFFFFF : -64'sd2147483648;
         oy = $urandom_range(0, 1) ? 32'sh7FFFFFFF : -64'sd2147483648;
      end else begin
         ox = longint'($urandom_range(0, 2000 * ONE)) - 1000 * ONE;
         oy = longint'($urandom_range(0, 2000 * ONE)) - 1000 * ONE;
      end
      // Mostly unit directions; sometimes raw 16-bit values, which the block
      // must use as they stand.
      if ($urandom_range(0, 4) == 0) begin
         dx = $signed(16'($urandom));
         dy = $signed(16'($urandom));
      end else begin
         a = $urandom_range(0, 62831) / 10000.0;
         dx = $rtoi(16384.0 * $cos(a));
         dy = $rtoi(16384.0 * $sin(a));
      end
      case ($urandom_range(0, 5))
         0: rad = 0;
         1: rad = 32'h7FFFFFFF;
         default: rad = $urandom_range(0, 4 * ONE);
      endcase
      case ($urandom_range(0, 5))
         0: maxd = 0;
         1: maxd = 32'h7FFFFFFF;
         default: maxd = $urandom_range(ONE, 300 * ONE);
      endcase
      set_config(ox, oy, rad, dx, dy, maxd);
   endtask

   initial begin
      int phase_items, cast_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed casts along +x from the origin with a swept radius of 1.0.
      set_config(0, 0, ONE, 16384, 0, 100 * ONE);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      send_item(20 * ONE, 0, 0, 0, ONE, 1, 1, 0);            // hit at 18
      send_item(10 * ONE, 3 * ONE, -2 * ONE, -3 * ONE, 2 * ONE, 1, 2, 0); // nearer
      send_item(5 * ONE, 0, 0, 0, ONE, 0, 3, 1);            // last item not a circle
      send_item(0, 0, 0, 0, 5 * ONE, 1, 4, 1);              // origin inside: far root
      send_item(0, 50 * ONE, 0, 0, ONE, 1, 5, 1);           // clean miss
      send_item(30 * ONE, ONE, 0, 0, ONE, 1, 6, 0);         // tie keeps the first
      send_item(30 * ONE, ONE, 0, 0, ONE, 1, 7, 1);
      send_item(200 * ONE, 0, 0, 0, ONE, 1, 8, 1);          // beyond the range
      send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 1, 16'hFFFF, 0);
      send_item(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                -64'sd2147483648, 0, 1, 0, 1);
      wait_drained();

      // Zero radii: the contact point lands on the candidate centre.
      set_config(0, 0, 0, 16384, 0, 100 * ONE);
      send_item(10 * ONE, 0, 0, 0, 0, 1, 9, 1);
      wait_drained();

      // Extreme setting with a direction that is not of unit length.
      set_config(-64'sd2147483648, 32'h7FFFFFFF, 32'h7FFFFFFF, -16384, 16384, 32'h7FFFFFFF);
      repeat (4) send_noise(0);
      send_noise(1);
      wait_drained();

      // Random phases: mostly casts aimed along the path, with some noise
      // candidates and casts of one item.
      while (items_sent < TOTAL_ITEMS) begin
         random_config();
         phase_items = $urandom_range(150, 250);
         if (phase_items > TOTAL_ITEMS - items_sent) phase_items = TOTAL_ITEMS - items_sent;
         while (phase_items > 0) begin
            cast_len = $urandom_range(1, 8);
            for (int k = 0; k < cast_len; k++) begin
               if ($urandom_range(0, 4) == 0) send_noise(k == cast_len - 1);
               else send_aimed(k == cast_len - 1);
            end
            phase_items -= cast_len;
         end
         wait_drained();
      end
      wait_drained();

      if (pending != 0) begin
         $display("%0t: %0d cast results never arrived", $time, pending);
      end
      $display("Sent %0d candidates over many register settings.", items_sent);
      $display("Checked %0d cast results, %0d of them hits.", result_count, hit_count);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #50000000;
      $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/scnh_pkg.sv
rtl/scnh_sqrt.sv
rtl/scnh_ctrl.sv
rtl/scnh_dpath.sv
rtl/swept_circle_nearest_hit_core.sv
test/swept_circle_nearest_hit_checker.sv
test/tb_swept_circle_nearest_hit_core.sv
